[rtl/core/swsl_pkg.sv]
`default_nettype none

package swsl_pkg;

    localparam int CountWidth  = 32;
    localparam int LengthWidth = 16;
    localparam int TolWidth    = 7;

    localparam logic [TolWidth-1:0] TolReset  = 7'd30;
    localparam logic [TolWidth:0]   LossScale = 8'd100;

    typedef enum logic [1:0] {
        REQ_NEW     = 2'd0,
        REQ_ACK     = 2'd1,
        REQ_TIMEOUT = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ACT_TX        = 2'd0,
        ACT_DELIVERED = 2'd1,
        ACT_ACCEPTED  = 2'd2,
        ACT_IGNORED   = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0]             req_type;
        logic                   ack_number;
        logic [LengthWidth-1:0] message_length;
    } t_in_word;

    typedef struct packed {
        logic [1:0]             action;
        logic                   sequence_bit;
        logic [LengthWidth-1:0] frame_length;
        logic [CountWidth-1:0]  losses_so_far;
        logic [CountWidth-1:0]  messages_so_far;
    } t_out_word;

endpackage

`default_nettype wire

[rtl/core/stop_wait_sender_loss_tolerant.sv]
// Channel   Direction  Signals                              Word
// input     in         i_in_valid, o_in_ready, i_in_word    t_in_word
// output    out        o_out_valid, i_out_ready, o_out_word t_out_word
// config    in         i_cfg_we, i_cfg_data                 loss tolerance percent
//
// A word that needs no loss test passes from acceptance through ST_EMIT to the output register.
// The first loss of a message runs a bit-serial ratio test in swsl_ratio, in state ST_CALC.
// One word is in work at a time; a new word is taken while a result waits in the output.
// Reset is synchronous and active low and sets the tolerance to 30.
`default_nettype none

module stop_wait_sender_loss_tolerant
    import swsl_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire t_in_word            i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output t_out_word                o_out_word,
    input  wire logic                i_cfg_we,
    input  wire logic [TolWidth-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_WAIT = 3'b010,
        PH_RETX = 3'b100
    } t_phase;

    t_state                 r_state, n_state;
    t_phase                 r_phase, n_phase;
    logic                   r_seq, n_seq;
    logic [CountWidth-1:0]  r_msg, n_msg;
    logic [CountWidth-1:0]  r_loss, n_loss;
    logic [LengthWidth-1:0] r_pend, n_pend;
    logic [TolWidth-1:0]    r_tol;
    logic [1:0]             r_act, n_act;
    logic                   r_rsb, n_rsb;
    logic [LengthWidth-1:0] r_rlen, n_rlen;
    t_out_word              r_out, n_out;
    logic                   r_out_valid, n_out_valid;

    logic                   in_acc;
    logic                   calc_start;
    logic                   calc_done;
    logic                   calc_ok;
    logic [CountWidth-1:0]  loss_inc;
    logic [CountWidth-1:0]  msg_inc;

    swsl_ratio #(
        .CNT_W (CountWidth)
    ) u_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (calc_start),
        .i_loss  (loss_inc),
        .i_msgs  (r_msg),
        .i_tol   (r_tol),
        .o_done  (calc_done),
        .o_ok    (calc_ok)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid & o_in_ready;
    assign loss_inc   = (r_loss == '1) ? r_loss : r_loss + 1'b1;
    assign msg_inc    = (r_msg == '1) ? r_msg : r_msg + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_seq       = r_seq;
        n_msg       = r_msg;
        n_loss      = r_loss;
        n_pend      = r_pend;
        n_act       = r_act;
        n_rsb       = r_rsb;
        n_rlen      = r_rlen;
        n_out       = r_out;
        n_out_valid = r_out_valid & ~i_out_ready;
        calc_start  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_EMIT;
                    n_rsb   = r_seq;
                    n_act   = ACT_IGNORED;
                    n_rlen  = '0;
                    if (i_in_word.req_type == REQ_NEW && r_phase == PH_IDLE) begin
                        n_pend  = i_in_word.message_length;
                        n_msg   = msg_inc;
                        n_phase = PH_WAIT;
                        n_act   = ACT_TX;
                        n_rlen  = i_in_word.message_length;
                    end else if ((i_in_word.req_type == REQ_ACK
                                  || i_in_word.req_type == REQ_TIMEOUT)
                                 && r_phase != PH_IDLE) begin
                        if (i_in_word.req_type == REQ_ACK
                            && i_in_word.ack_number == ~r_seq) begin
                            n_seq   = ~r_seq;
                            n_phase = PH_IDLE;
                            n_act   = ACT_DELIVERED;
                        end else if (r_phase == PH_WAIT) begin
                            n_loss     = loss_inc;
                            calc_start = 1'b1;
                            n_state    = ST_CALC;
                        end else begin
                            n_act  = ACT_TX;
                            n_rlen = r_pend;
                        end
                    end
                end
            end
            ST_CALC: begin
                if (calc_done) begin
                    n_state = ST_EMIT;
                    if (calc_ok) begin
                        n_seq   = ~r_seq;
                        n_phase = PH_IDLE;
                        n_act   = ACT_ACCEPTED;
                        n_rlen  = '0;
                    end else begin
                        n_phase = PH_RETX;
                        n_act   = ACT_TX;
                        n_rlen  = r_pend;
                    end
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.action          = r_act;
                    n_out.sequence_bit    = r_rsb;
                    n_out.frame_length    = r_rlen;
                    n_out.losses_so_far   = r_loss;
                    n_out.messages_so_far = r_msg;
                    n_out_valid           = 1'b1;
                    n_state               = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_IDLE;
            r_seq       <= 1'b0;
            r_msg       <= '0;
            r_loss      <= '0;
            r_pend      <= '0;
            r_tol       <= TolReset;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_seq       <= n_seq;
            r_msg       <= n_msg;
            r_loss      <= n_loss;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_tol <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act  <= n_act;
        r_rsb  <= n_rsb;
        r_rlen <= n_rlen;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

[rtl/core/swsl_ratio.sv]
`default_nettype none

module swsl_ratio
    import swsl_pkg::*;
#(
    parameter int CNT_W = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [CNT_W-1:0]    i_loss,
    input  wire logic [CNT_W-1:0]    i_msgs,
    input  wire logic [TolWidth-1:0] i_tol,
    output logic                     o_done,
    output logic                     o_ok
);

    // Both products are formed one bit a cycle, LSB first, and compared as they appear.
    localparam int NSteps = CNT_W + TolWidth;
    localparam int CntW   = $clog2(NSteps);
    localparam logic [CntW-1:0] LastStep = CntW'(NSteps - 1);

    logic [CNT_W-1:0]    r_l;
    logic [CNT_W-1:0]    r_m;
    logic [TolWidth-1:0] r_ca;
    logic [TolWidth-1:0] r_cb;
    logic                r_lt;
    logic                r_nz;
    logic                r_busy;
    logic                r_done;
    logic [CntW-1:0]     r_cnt;

    logic [TolWidth:0] mult_b;
    logic [TolWidth:0] s_a;
    logic [TolWidth:0] s_b;

    always_comb begin
        mult_b = {1'b0, i_tol} + {{TolWidth{1'b0}}, 1'b1};
        s_a    = {1'b0, r_ca} + (r_l[0] ? LossScale : '0);
        s_b    = {1'b0, r_cb} + (r_m[0] ? mult_b : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == LastStep) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_l   <= i_loss;
            r_m   <= i_msgs;
            r_ca  <= '0;
            r_cb  <= '0;
            r_lt  <= 1'b0;
            r_nz  <= 1'b0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_l   <= {1'b0, r_l[CNT_W-1:1]};
            r_m   <= {1'b0, r_m[CNT_W-1:1]};
            r_ca  <= s_a[TolWidth:1];
            r_cb  <= s_b[TolWidth:1];
            r_lt  <= (s_a[0] != s_b[0]) ? s_b[0] : r_lt;
            r_nz  <= r_nz | r_m[0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_ok   = r_lt & r_nz;

endmodule

`default_nettype wire

[rtl/core/swsl_checker.sv]
`default_nettype none

module swsl_checker
    import swsl_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      o_out_valid,
    input  wire logic      i_out_ready,
    input  wire t_out_word o_out_word
);

    // A word that waits at the output holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    // Only a transmitted frame carries a length.
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.action != ACT_TX |-> o_out_word.frame_length == '0)
        else $error("nonzero length on a word that is not a frame");

    // Losses are counted only against sent messages.
    a_loss_le_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.losses_so_far <= o_out_word.messages_so_far)
        else $error("loss count exceeds message count");

    // Reset leaves no word at the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind stop_wait_sender_loss_tolerant swsl_checker u_swsl_checker (.*);

`default_nettype wire

[tb/stop_wait_sender_loss_tolerant_tb.sv]
`timescale 1ns / 100ps

module stop_wait_sender_loss_tolerant_tb;
    import swsl_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 4000;
    localparam int RANDOM_WORDS = 1500;
    localparam int TOTAL_WORDS = 1700;

    typedef enum logic [1:0] {
        LINK_IDLE,
        LINK_WAIT,
        LINK_RETX
    } t_link_phase;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    t_in_word in_word = '0;
    logic out_ready = 1'b0;
    logic cfg_we = 1'b0;
    logic [TolWidth-1:0] cfg_data = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out_word o_out_word;

    logic [TolWidth-1:0] tolerance = TolReset;
    logic link_seq = 1'b0;
    t_link_phase link_phase = LINK_IDLE;
    logic [CountWidth-1:0] message_total = '0;
    logic [CountWidth-1:0] loss_total = '0;
    logic [LengthWidth-1:0] held_length = '0;

    t_out_word awaited_results[$];
    bit bursts_on = 1'b1;
    int words_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int action_hits[4] = '{0, 0, 0, 0};
    int stall_left = 0;
    int quiet_cycles = 0;

    stop_wait_sender_loss_tolerant i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic bit loss_within_tolerance();
        logic [63:0] scaled_losses;
        logic [63:0] allowed;
        scaled_losses = 64'(loss_total) * 64'(LossScale);
        allowed = 64'(message_total) * (64'(tolerance) + 64'd1);
        return (message_total != '0) && (scaled_losses < allowed);
    endfunction

    function automatic t_out_word arq_outcome(t_in_word w);
        t_out_word r;
        logic sb;
        bit accepted;
        sb = link_seq;
        accepted = 1'b0;
        r = '0;
        r.action = ACT_IGNORED;
        r.sequence_bit = sb;
        if (w.req_type == REQ_NEW && link_phase == LINK_IDLE) begin
            held_length = w.message_length;
            if (message_total != '1) message_total++;
            link_phase = LINK_WAIT;
            r.action = ACT_TX;
            r.frame_length = w.message_length;
        end else if ((w.req_type == REQ_ACK || w.req_type == REQ_TIMEOUT)
                     && link_phase != LINK_IDLE) begin
            if (w.req_type == REQ_ACK && w.ack_number == !sb) begin
                link_seq = !sb;
                link_phase = LINK_IDLE;
                r.action = ACT_DELIVERED;
            end else begin
                if (link_phase == LINK_WAIT) begin
                    if (loss_total != '1) loss_total++;
                    link_phase = LINK_RETX;
                    if (loss_within_tolerance()) begin
                        link_seq = !sb;
                        link_phase = LINK_IDLE;
                        accepted = 1'b1;
                        r.action = ACT_ACCEPTED;
                    end
                end
                if (!accepted) begin
                    r.action = ACT_TX;
                    r.frame_length = held_length;
                end
            end
        end
        r.losses_so_far = loss_total;
        r.messages_so_far = message_total;
        return r;
    endfunction

    function automatic t_in_word make_word(logic [1:0] req, logic ack,
                                           logic [LengthWidth-1:0] len);
        t_in_word w;
        w.req_type = req;
        w.ack_number = ack;
        w.message_length = len;
        return w;
    endfunction

    function automatic logic [LengthWidth-1:0] rand_length();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return LengthWidth'($urandom);
        endcase
    endfunction

    task automatic send_word(t_in_word w);
        int gap;
        if (bursts_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (!o_in_ready);
        awaited_results.push_back(arq_outcome(w));
        words_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_tolerance(logic [TolWidth-1:0] value);
        settle();
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        tolerance = value;
        cfg_we <= 1'b0;
    endtask

    task automatic send_matching_ack();
        send_word(make_word(REQ_ACK, !link_seq, rand_length()));
    endtask

    task automatic send_loss();
        if ($urandom_range(0, 1))
            send_word(make_word(REQ_TIMEOUT, 1'($urandom), rand_length()));
        else
            send_word(make_word(REQ_ACK, link_seq, rand_length()));
    endtask

    task automatic test_out_of_phase_items();
        send_word(make_word(REQ_ACK, 1'b1, 16'hFFFF));
        send_word(make_word(REQ_TIMEOUT, 1'b0, 16'h0000));
        send_word(make_word(REQ_UNUSED, 1'b1, 16'hFFFF));
        send_word(make_word(REQ_NEW, 1'b0, 16'h0000));
        send_word(make_word(REQ_NEW, 1'b1, 16'h1234));
        send_word(make_word(REQ_UNUSED, 1'b0, 16'h0000));
    endtask

    task automatic test_first_loss_and_retransmit();
        send_word(make_word(REQ_ACK, link_seq, 16'h0F0F));
        send_word(make_word(REQ_TIMEOUT, 1'b1, 16'hF0F0));
        send_matching_ack();
        send_word(make_word(REQ_NEW, 1'b1, 16'hFFFF));
        send_word(make_word(REQ_TIMEOUT, 1'b0, 16'h0001));
        send_word(make_word(REQ_ACK, link_seq, 16'h8000));
        send_matching_ack();
    endtask

    task automatic test_tolerance_extremes();
        set_tolerance(7'd100);
        send_word(make_word(REQ_NEW, 1'b0, 16'hAAAA));
        send_word(make_word(REQ_ACK, link_seq, 16'h0000));
        set_tolerance(7'd127);
        send_word(make_word(REQ_NEW, 1'b1, 16'h5555));
        send_word(make_word(REQ_TIMEOUT, 1'b0, 16'h0000));
        set_tolerance(7'd0);
        send_word(make_word(REQ_NEW, 1'b0, 16'h7FFF));
        send_word(make_word(REQ_TIMEOUT, 1'b1, 16'h0000));
        send_matching_ack();
    endtask

    task automatic run_exchange();
        int losses;
        if ($urandom_range(0, 9) == 0)
            send_word(make_word(2'($urandom_range(0, 3)), 1'($urandom), rand_length()));
        if (link_phase == LINK_IDLE)
            send_word(make_word(REQ_NEW, 1'($urandom), rand_length()));
        losses = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 4);
        for (int k = 0; k < losses && link_phase != LINK_IDLE; k++) begin
            if ($urandom_range(0, 7) == 0)
                send_word(make_word($urandom_range(0, 1) ? REQ_NEW : REQ_UNUSED,
                                    1'($urandom), rand_length()));
            send_loss();
        end
        if (link_phase != LINK_IDLE) send_matching_ack();
    endtask

    task automatic test_random_exchanges();
        logic [TolWidth-1:0] settings[6];
        settings = '{7'd30, 7'd0, 7'd50, 7'd100, 7'd127, 7'd30};
        for (int p = 0; p < 6; p++) begin
            set_tolerance(p == 5 ? TolWidth'($urandom_range(0, 127)) : settings[p]);
            bursts_on = (p != 2);
            while (words_sent < (p + 1) * RANDOM_WORDS / 6) run_exchange();
        end
    endtask

    task automatic test_back_to_back();
        set_tolerance(TolWidth'($urandom_range(20, 60)));
        bursts_on = 1'b0;
        while (words_sent < TOTAL_WORDS) run_exchange();
    endtask

    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (bursts_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        t_out_word exp;
        if (rst_n && o_out_valid && out_ready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with none expected: %h", $time, o_out_word);
            end else begin
                exp = awaited_results.pop_front();
                action_hits[o_out_word.action]++;
                if (o_out_word.action !== exp.action
                    || o_out_word.sequence_bit !== exp.sequence_bit
                    || o_out_word.frame_length !== exp.frame_length
                    || o_out_word.losses_so_far !== exp.losses_so_far
                    || o_out_word.messages_so_far !== exp.messages_so_far) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: expected act %0d seq %0d len %0d loss %0d msg %0d",
                                 $time, exp.action, exp.sequence_bit, exp.frame_length,
                                 exp.losses_so_far, exp.messages_so_far);
                        $display("%0t: actual   act %0d seq %0d len %0d loss %0d msg %0d",
                                 $time, o_out_word.action, o_out_word.sequence_bit,
                                 o_out_word.frame_length, o_out_word.losses_so_far,
                                 o_out_word.messages_so_far);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Watchdog expired with %0d results outstanding.",
                         awaited_results.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_out_of_phase_items();
        test_first_loss_and_retransmit();
        test_tolerance_extremes();
        test_random_exchanges();
        test_back_to_back();
        settle();
        $display("Sent %0d words and checked %0d results: %0d transmits, %0d deliveries,",
                 words_sent, results_seen, action_hits[ACT_TX], action_hits[ACT_DELIVERED]);
        $display("%0d accepted losses and %0d ignored words across tolerances 0 to 127.",
                 action_hits[ACT_ACCEPTED], action_hits[ACT_IGNORED]);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches.", mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
